FILE: rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
// No dependencies; used by the top level and its checker.
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int RANK_W  = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 16;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;

  localparam int IN_DATA_W  = KEY_W + VAL_W;
  localparam int OUT_DATA_W = VAL_W + KEY_W;
  localparam int OUT_USER_W = 2;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam int USER_HIT     = 0;
  localparam int USER_EVICTED = 1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [RANK_W-1:0]       rank_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  localparam val_t READ_MISS = '1;

endpackage

FILE: rtl/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
// Depends on lkvc_pkg for widths, command codes and types.
//
//  channel | dir | tdata / data                         | tuser
//  in_     | in  | [15:0] key, [47:16] value            | [0] command
//  out_    | out | [31:0] read_value, [47:32] evict key | [0] hit, [1] evicted
//  cfg_    | in  | [4:0] capacity                       | -
//
// One beat per cycle unless the output stalls; input register, then result register.
// The input register feeds one pass of 16 key compares and rank updates.
// Reset clears all entries; capacity returns to 16 and cfg_ready stays high.
// A stall on the result side holds the result and then the input register.
module lru_key_value_cache (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lkvc_pkg::IN_DATA_W-1:0]  in_tdata,   // key, value
  input  logic                            in_tuser,   // command
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lkvc_pkg::OUT_DATA_W-1:0] out_tdata,  // read_value, evicted_key
  output logic [lkvc_pkg::OUT_USER_W-1:0] out_tuser,  // hit, evicted
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0]      cfg_data
);

  logic                       in_valid_r;
  logic                       in_cmd_r;
  lkvc_pkg::key_t             in_key_r;
  lkvc_pkg::val_t             in_val_r;
  logic [lkvc_pkg::CAP_W-1:0] cap_r;

  lkvc_pkg::key_t  key_r   [lkvc_pkg::ENTRIES];
  lkvc_pkg::val_t  val_r   [lkvc_pkg::ENTRIES];
  lkvc_pkg::rank_t rank_r  [lkvc_pkg::ENTRIES];
  lkvc_pkg::rank_t rank_nxt[lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::ENTRIES-1:0] valid_r, valid_nxt;
  lkvc_pkg::cnt_t  occ_r, occ_nxt;

  logic           out_valid_r;
  logic           out_hit_r, out_evict_r;
  lkvc_pkg::val_t out_rdval_r;
  lkvc_pkg::key_t out_ekey_r;

  logic [lkvc_pkg::ENTRIES-1:0] match, victim_oh, free_oh;
  lkvc_pkg::idx_t hit_idx, victim_idx, free_idx, tgt_idx;
  logic           hit, full, is_put, evict, do_touch, do_write;
  lkvc_pkg::cnt_t limit, old_rank;
  lkvc_pkg::val_t rdval;
  lkvc_pkg::key_t ekey;
  logic           advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign is_put    = (in_cmd_r == lkvc_pkg::CMD_PUT);

  always_comb begin
    if (cap_r == '0) begin
      limit = lkvc_pkg::cnt_t'(1);
    end else if (cap_r > lkvc_pkg::CAP_W'(lkvc_pkg::ENTRIES)) begin
      limit = lkvc_pkg::cnt_t'(lkvc_pkg::ENTRIES);
    end else begin
      limit = lkvc_pkg::cnt_t'(cap_r);
    end
  end

  assign full = (occ_r >= limit);

  always_comb begin
    match      = '0;
    victim_oh  = '0;
    free_oh    = '0;
    hit_idx    = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      match[i]     = valid_r[i] && (key_r[i] == in_key_r);
      victim_oh[i] = valid_r[i] && (lkvc_pkg::cnt_t'(rank_r[i]) + 1'b1 == occ_r);
      free_oh[i]   = !valid_r[i];
    end
    for (int i = lkvc_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (match[i])     hit_idx    = lkvc_pkg::idx_t'(i);
      if (victim_oh[i]) victim_idx = lkvc_pkg::idx_t'(i);
      if (free_oh[i])   free_idx   = lkvc_pkg::idx_t'(i);
    end
  end

  assign hit   = |match;
  assign evict = is_put && !hit && full && (|victim_oh);
  assign ekey  = evict ? key_r[victim_idx] : '0;
  assign rdval = is_put ? in_val_r : (hit ? val_r[hit_idx] : lkvc_pkg::READ_MISS);

  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    tgt_idx   = hit_idx;
    old_rank  = lkvc_pkg::cnt_t'(rank_r[hit_idx]);
    do_touch  = 1'b0;
    do_write  = 1'b0;
    if (hit) begin
      do_touch = 1'b1;
      do_write = is_put;
    end else if (is_put && full) begin
      tgt_idx  = victim_idx;
      old_rank = occ_r - 1'b1;
      do_touch = evict;
      do_write = evict;
    end else if (is_put && (|free_oh)) begin
      tgt_idx            = free_idx;
      old_rank           = occ_r;
      do_touch           = 1'b1;
      do_write           = 1'b1;
      valid_nxt[free_idx] = 1'b1;
      occ_nxt            = occ_r + 1'b1;
    end
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (do_touch) begin
        if (lkvc_pkg::idx_t'(i) == tgt_idx) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (lkvc_pkg::cnt_t'(rank_r[i]) < old_rank)) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cap_r       <= lkvc_pkg::CAP_RESET;
      valid_r     <= '0;
      occ_r       <= '0;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        valid_r     <= valid_nxt;
        occ_r       <= occ_nxt;
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
          rank_r[i] <= rank_nxt[i];
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_cmd_r <= in_tuser;
      in_key_r <= in_tdata[lkvc_pkg::KEY_W-1:0];
      in_val_r <= in_tdata[lkvc_pkg::IN_DATA_W-1:lkvc_pkg::KEY_W];
    end
    if (advance) begin
      out_hit_r   <= hit;
      out_evict_r <= evict;
      out_rdval_r <= rdval;
      out_ekey_r  <= ekey;
      if (do_write) begin
        key_r[tgt_idx] <= in_key_r;
        val_r[tgt_idx] <= in_val_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ekey_r, out_rdval_r};
  assign out_tuser  = {out_evict_r, out_hit_r};

endmodule

FILE: rtl/lkvc_checker.sv
// Port-level checker for the LRU key-value cache, bound to the top level.
// Depends on lkvc_pkg for field positions.
module lkvc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lkvc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [lkvc_pkg::OUT_USER_W-1:0] out_tuser
);

  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[lkvc_pkg::USER_HIT] && out_tuser[lkvc_pkg::USER_EVICTED]))
    else $error("eviction reported on a hit");

  a_ekey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[lkvc_pkg::USER_EVICTED])
      |-> (out_tdata[lkvc_pkg::OUT_DATA_W-1:lkvc_pkg::VAL_W] == '0))
    else $error("evicted key nonzero without eviction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result beat changed");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: test/tb_lru_key_value_cache.sv
// Testbench for lru_key_value_cache: directed and random get/put traffic, checked against
// an in-bench LRU predictor, across several capacity settings with random stalls.
// Depends on rtl/lkvc_pkg.sv and rtl/lru_key_value_cache.sv.
module tb_lru_key_value_cache;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int PRINT_LIMIT = 40;
  localparam int PHASE_ITEMS = 135;

  typedef struct {
    logic hit;
    lkvc_pkg::val_t read_value;
    logic evicted;
    lkvc_pkg::key_t evicted_key;
  } access_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [lkvc_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = lkvc_pkg::CMD_GET;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [lkvc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [lkvc_pkg::OUT_USER_W-1:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lkvc_pkg::CAP_W-1:0] cfg_data = '0;

  // predictor state
  lkvc_pkg::key_t slot_key[lkvc_pkg::ENTRIES];
  lkvc_pkg::val_t slot_val[lkvc_pkg::ENTRIES];
  logic slot_used[lkvc_pkg::ENTRIES];
  int   slot_age[lkvc_pkg::ENTRIES];
  int   used_count = 0;
  int   capacity_reg = lkvc_pkg::ENTRIES;

  access_result_t pending_results[$];
  int fail_count = 0;
  int stall_cycles = 0;
  int send_quiet = 0;
  int recv_quiet = 0;

  lru_key_value_cache dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      slot_key[i] = '0;
      slot_val[i] = '0;
      slot_used[i] = 1'b0;
      slot_age[i] = 0;
    end
  end

  function automatic int draw_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic void promote(int s, int old_age);
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      if (slot_used[i] && i != s && slot_age[i] < old_age) slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  function automatic access_result_t predict_access(logic cmd, lkvc_pkg::key_t k,
                                                    lkvc_pkg::val_t v);
    access_result_t r;
    int found;
    int victim;
    int oldest;
    int eff_cap;
    r.hit = 1'b0;
    r.read_value = lkvc_pkg::READ_MISS;
    r.evicted = 1'b0;
    r.evicted_key = '0;
    found = -1;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      if (found < 0 && slot_used[i] && slot_key[i] == k) found = i;
    end
    eff_cap = (capacity_reg == 0) ? 1 :
              ((capacity_reg > lkvc_pkg::ENTRIES) ? lkvc_pkg::ENTRIES : capacity_reg);
    if (cmd == lkvc_pkg::CMD_GET) begin
      if (found >= 0) begin
        r.hit = 1'b1;
        r.read_value = slot_val[found];
        promote(found, slot_age[found]);
      end
    end else begin
      r.read_value = v;
      if (found >= 0) begin
        r.hit = 1'b1;
        slot_val[found] = v;
        promote(found, slot_age[found]);
      end else if (used_count >= eff_cap) begin
        victim = -1;
        oldest = 0;
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
          if (slot_used[i] && (victim < 0 || slot_age[i] > oldest)) begin
            victim = i;
            oldest = slot_age[i];
          end
        end
        if (victim >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = slot_key[victim];
          slot_key[victim] = k;
          slot_val[victim] = v;
          promote(victim, oldest);
        end
      end else begin
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
          if (found < 0 && !slot_used[i]) found = i;
        end
        if (found >= 0) begin
          slot_used[found] = 1'b1;
          slot_key[found] = k;
          slot_val[found] = v;
          promote(found, used_count);
          used_count++;
        end
      end
    end
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (expv !== actv) begin
      if (fail_count < PRINT_LIMIT)
        $error("%s: expected %0h, got %0h", name, expv, actv);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    access_result_t exp_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          if (fail_count < PRINT_LIMIT) $error("result beat with no access outstanding");
          fail_count++;
        end else begin
          exp_r = pending_results[0];
          pending_results.delete(0);
          compare_field("hit", 32'(exp_r.hit), 32'(out_tuser[lkvc_pkg::USER_HIT]));
          compare_field("read_value", exp_r.read_value, out_tdata[31:0]);
          compare_field("evicted", 32'(exp_r.evicted),
                        32'(out_tuser[lkvc_pkg::USER_EVICTED]));
          compare_field("evicted_key", 32'(exp_r.evicted_key),
                        32'(lkvc_pkg::key_t'(out_tdata[47:32])));
        end
      end
      if (in_tvalid && in_tready)
        pending_results.insert(pending_results.size(),
                               predict_access(in_tuser, in_tdata[15:0], in_tdata[47:16]));
      if (cfg_valid && cfg_ready) capacity_reg = int'(cfg_data);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("** lru_key_value_cache: FAILED **");
      $finish;
    end
  end

  initial begin
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = draw_gap(recv_quiet);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_access(input logic cmd, input lkvc_pkg::key_t k,
                             input lkvc_pkg::val_t v);
    int gap;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {v, k};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_lookups();
    send_access(lkvc_pkg::CMD_GET, lkvc_pkg::key_t'(0), lkvc_pkg::val_t'(0));
    send_access(lkvc_pkg::CMD_GET, lkvc_pkg::key_t'(16'h7FFF),
                lkvc_pkg::val_t'(32'h1234_5678));
  endtask

  task automatic test_field_extremes();
    send_access(lkvc_pkg::CMD_PUT, lkvc_pkg::key_t'(16'h8000),
                lkvc_pkg::val_t'(32'h8000_0000));
    send_access(lkvc_pkg::CMD_PUT, lkvc_pkg::key_t'(16'h7FFF),
                lkvc_pkg::val_t'(32'h7FFF_FFFF));
    send_access(lkvc_pkg::CMD_PUT, lkvc_pkg::key_t'(0), lkvc_pkg::val_t'(0));
    send_access(lkvc_pkg::CMD_PUT, lkvc_pkg::key_t'(16'hFFFF),
                lkvc_pkg::val_t'(32'hFFFF_FFFF));
    send_access(lkvc_pkg::CMD_GET, lkvc_pkg::key_t'(16'h8000), lkvc_pkg::val_t'(0));
    send_access(lkvc_pkg::CMD_GET, lkvc_pkg::key_t'(0), lkvc_pkg::val_t'(32'hFFFF_FFFF));
    send_access(lkvc_pkg::CMD_GET, lkvc_pkg::key_t'(16'hFFFF), lkvc_pkg::val_t'(0));
  endtask

  task automatic test_update_order();
    send_access(lkvc_pkg::CMD_PUT, lkvc_pkg::key_t'(0), lkvc_pkg::val_t'(32'h5A5A_A5A5));
    send_access(lkvc_pkg::CMD_PUT, lkvc_pkg::key_t'(0), lkvc_pkg::val_t'(32'hA5A5_5A5A));
    send_access(lkvc_pkg::CMD_GET, lkvc_pkg::key_t'(5), lkvc_pkg::val_t'(0));
  endtask

  task automatic test_capacity_edges();
    set_capacity(5'd0);
    send_access(lkvc_pkg::CMD_PUT, lkvc_pkg::key_t'(100), lkvc_pkg::val_t'(32'd1000));
    send_access(lkvc_pkg::CMD_PUT, lkvc_pkg::key_t'(101), lkvc_pkg::val_t'(32'd1001));
    send_access(lkvc_pkg::CMD_GET, lkvc_pkg::key_t'(101), lkvc_pkg::val_t'(0));
    send_access(lkvc_pkg::CMD_GET, lkvc_pkg::key_t'(100), lkvc_pkg::val_t'(0));
    set_capacity(5'd31);
    send_access(lkvc_pkg::CMD_PUT, lkvc_pkg::key_t'(200), lkvc_pkg::val_t'(32'd2000));
    send_access(lkvc_pkg::CMD_PUT, lkvc_pkg::key_t'(201), lkvc_pkg::val_t'(32'd2001));
    set_capacity(5'd2);
    send_access(lkvc_pkg::CMD_PUT, lkvc_pkg::key_t'(300), lkvc_pkg::val_t'(32'd3000));
    send_access(lkvc_pkg::CMD_GET, lkvc_pkg::key_t'(201), lkvc_pkg::val_t'(0));
    send_access(lkvc_pkg::CMD_PUT, lkvc_pkg::key_t'(301), lkvc_pkg::val_t'(32'd3001));
    send_access(lkvc_pkg::CMD_GET, lkvc_pkg::key_t'(300), lkvc_pkg::val_t'(0));
  endtask

  task automatic test_random_traffic(input logic [lkvc_pkg::CAP_W-1:0] cap);
    lkvc_pkg::key_t base;
    lkvc_pkg::key_t k;
    int spread;
    logic cmd;
    set_capacity(cap);
    base = lkvc_pkg::key_t'($urandom);
    spread = ((cap == 0) ? 1 :
              ((cap > lkvc_pkg::ENTRIES) ? lkvc_pkg::ENTRIES : int'(cap))) + 3;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if ($urandom_range(0, 7) == 0)
        k = lkvc_pkg::key_t'($urandom);
      else
        k = base + lkvc_pkg::key_t'($urandom_range(0, spread));
      cmd = $urandom_range(0, 1) ? lkvc_pkg::CMD_PUT : lkvc_pkg::CMD_GET;
      send_access(cmd, k, lkvc_pkg::val_t'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_lookups();
    test_field_extremes();
    test_update_order();
    test_capacity_edges();
    test_random_traffic(5'd16);
    test_random_traffic(5'd1);
    test_random_traffic(5'd31);
    test_random_traffic(5'd0);
    test_random_traffic(5'd3);
    test_random_traffic(5'($urandom_range(0, 31)));
    test_random_traffic(5'd2);
    test_random_traffic(5'd8);
    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("** lru_key_value_cache: PASSED **");
    else
      $display("** lru_key_value_cache: FAILED **");
    $finish;
  end

endmodule

FILE: lru_key_value_cache.f
rtl/lkvc_pkg.sv
rtl/lru_key_value_cache.sv
rtl/lkvc_checker.sv
test/tb_lru_key_value_cache.sv
